// ----- design/cmhsv_pkg.sv -----
// ----------------------------------------------------------------------------
// cmhsv_pkg: shared types and constants
// Operation codes, state types and the request bundle of the serial
// multiply-divide unit of the HSV/RGB color register block.
// ----------------------------------------------------------------------------
package cmhsv_pkg;

  localparam logic [2:0] OP_HUE   = 3'd0;
  localparam logic [2:0] OP_SAT   = 3'd1;
  localparam logic [2:0] OP_VAL   = 3'd2;
  localparam logic [2:0] OP_RED   = 3'd3;
  localparam logic [2:0] OP_GREEN = 3'd4;
  localparam logic [2:0] OP_BLUE  = 3'd5;

  localparam logic [8:0] HUE_MAX  = 9'd359;
  localparam logic [7:0] PCT_MAX  = 8'd100;
  localparam logic [7:0] CH_MAX   = 8'd255;
  localparam logic [7:0] SEXT_DEG = 8'd60;
  localparam logic [9:0] FULL_DEG = 10'd360;
  localparam logic [8:0] HUE_GRN  = 9'd120;
  localparam logic [8:0] HUE_BLU  = 9'd240;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HSV_GO,
    S_RF,
    S_LT,
    S_LZ,
    S_SD,
    S_ST,
    S_SZ,
    S_RGB_GO,
    S_RV,
    S_RS,
    S_RH,
    S_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  // q = (a * b) / c, truncating
  typedef struct packed {
    logic       start;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } md_req_t;

endpackage

// ----- design/cmhsv_muldiv.sv -----
// ----------------------------------------------------------------------------
// cmhsv_muldiv: bit-serial multiply then divide
// Shift-add multiply over the 8 multiplier bits, restoring divide one quotient bit per
// cycle for 16 quotient bits. done pulses with the quotient on q.
// ----------------------------------------------------------------------------
module cmhsv_muldiv
  import cmhsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  md_req_t    req,
  output logic       done,
  output logic [7:0] q
);

  md_state_t   state_r, state_nxt;
  logic [15:0] mc_r, mc_nxt;
  logic [7:0]  mp_r, mp_nxt;
  logic [15:0] prod_r, prod_nxt;
  logic [7:0]  c_r, c_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [8:0]  rem_sh;
  logic [8:0]  rem_sub;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    mc_r   <= mc_nxt;
    mp_r   <= mp_nxt;
    prod_r <= prod_nxt;
    c_r    <= c_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    mc_nxt    = mc_r;
    mp_nxt    = mp_r;
    prod_nxt  = prod_r;
    c_nxt     = c_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    rem_sh    = {rem_r, prod_r[15]};
    rem_sub   = rem_sh - {1'b0, c_r};
    unique case (state_r)
      MD_IDLE: begin
        if (req.start) begin
          mc_nxt    = {8'd0, req.a};
          mp_nxt    = req.b;
          prod_nxt  = 16'd0;
          c_nxt     = req.c;
          cnt_nxt   = 4'd0;
          state_nxt = MD_MUL;
        end
      end
      MD_MUL: begin
        if (mp_r[0]) begin
          prod_nxt = prod_r + mc_r;
        end
        mc_nxt  = {mc_r[14:0], 1'b0};
        mp_nxt  = {1'b0, mp_r[7:1]};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd7) begin
          cnt_nxt   = 4'd0;
          rem_nxt   = 8'd0;
          state_nxt = MD_DIV;
        end
      end
      MD_DIV: begin
        if (rem_sh >= {1'b0, c_r}) begin
          rem_nxt  = rem_sub[7:0];
          prod_nxt = {prod_r[14:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh[7:0];
          prod_nxt = {prod_r[14:0], 1'b0};
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          done_nxt  = 1'b1;
          state_nxt = MD_IDLE;
        end
      end
      default: state_nxt = MD_IDLE;
    endcase
  end

  assign done = done_r;
  assign q    = prod_r[7:0];

endmodule

// ----- design/colour_model_hsv_rgb_sync_unit.sv -----
// ----------------------------------------------------------------------------
// colour_model_hsv_rgb_sync_unit: HSV/RGB color register block
// Holds one color in both HSV and RGB form and keeps the two in step.
//
// Each input transaction (in_operation, in_new_value) writes one component;
// each yields one output transaction with the changed flag and all six
// components. A write equal to the stored value, or an unused operation
// code, skips all scaling and loads the output register as soon as it is free.
// An RGB write loads it after up to three scaling steps, an HSV write after
// six: every scaling step runs through one shared bit-serial multiply-divide
// unit (8 multiply bits, 16 quotient bits, handoff); black stops after one
// RGB step, gray after two.
// One transaction is worked on at a time; in_stall is high while busy and
// drops in the same cycle that the result appears in the output register.
// A finished result sits in the output register while out_stall is high,
// and the next input transaction is taken meanwhile; its result waits until
// the register is free.
// Reset clears all components to zero (black) and empties the output.
// ----------------------------------------------------------------------------
module colour_model_hsv_rgb_sync_unit
  import cmhsv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_operation,
  input  logic signed [9:0] in_new_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_changed,
  output logic [8:0]        out_hue_out,
  output logic [6:0]        out_sat_out,
  output logic [6:0]        out_val_out,
  output logic [7:0]        out_red_out,
  output logic [7:0]        out_green_out,
  output logic [7:0]        out_blue_out
);

  ctl_state_t state_r, state_nxt;
  logic [8:0] hue_r, hue_nxt;
  logic [6:0] sat_r, sat_nxt;
  logic [6:0] val_r, val_nxt;
  logic [7:0] red_r, red_nxt;
  logic [7:0] green_r, green_nxt;
  logic [7:0] blue_r, blue_nxt;
  logic [2:0] sext_r, sext_nxt;
  logic [7:0] t_r, t_nxt;
  logic [7:0] lt_r, lt_nxt;
  logic [7:0] lz_r, lz_nxt;
  logic       chg_r, chg_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       o_chg_r, o_chg_nxt;
  logic [8:0] o_hue_r, o_hue_nxt;
  logic [6:0] o_sat_r, o_sat_nxt;
  logic [6:0] o_val_r, o_val_nxt;
  logic [7:0] o_red_r, o_red_nxt;
  logic [7:0] o_green_r, o_green_nxt;
  logic [7:0] o_blue_r, o_blue_nxt;

  md_req_t    md_req;
  logic       md_done;
  logic [7:0] md_q;

  logic signed [9:0] cur_s;
  logic signed [9:0] top_s;
  logic              op_ok;
  logic              to_rgb;
  logic [8:0]        clv;
  logic [2:0]        sext;
  logic [8:0]        sext_base;
  logic [8:0]        f_full;
  logic [5:0]        f;
  logic [7:0]        inv_sat;
  logic [7:0]        mx;
  logic [7:0]        mn;
  logic [7:0]        dd;
  logic signed [8:0] dif;
  logic [7:0]        mag;
  logic [8:0]        hbase;
  logic signed [9:0] hs;
  logic              ch_wr;
  chan_t             ch_sel;

  cmhsv_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .done  (md_done),
    .q     (md_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hue_r       <= 9'd0;
      sat_r       <= 7'd0;
      val_r       <= 7'd0;
      red_r       <= 8'd0;
      green_r     <= 8'd0;
      blue_r      <= 8'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hue_r       <= hue_nxt;
      sat_r       <= sat_nxt;
      val_r       <= val_nxt;
      red_r       <= red_nxt;
      green_r     <= green_nxt;
      blue_r      <= blue_nxt;
    end
    sext_r    <= sext_nxt;
    t_r       <= t_nxt;
    lt_r      <= lt_nxt;
    lz_r      <= lz_nxt;
    chg_r     <= chg_nxt;
    o_chg_r   <= o_chg_nxt;
    o_hue_r   <= o_hue_nxt;
    o_sat_r   <= o_sat_nxt;
    o_val_r   <= o_val_nxt;
    o_red_r   <= o_red_nxt;
    o_green_r <= o_green_nxt;
    o_blue_r  <= o_blue_nxt;
  end

  // input decode and clamp
  always_comb begin
    cur_s  = 10'sd0;
    top_s  = 10'sd0;
    op_ok  = 1'b1;
    to_rgb = 1'b0;
    unique case (in_operation)
      OP_HUE: begin
        cur_s  = $signed({1'b0, hue_r});
        top_s  = $signed({1'b0, HUE_MAX});
        to_rgb = 1'b1;
      end
      OP_SAT: begin
        cur_s  = $signed({3'b0, sat_r});
        top_s  = $signed({2'b0, PCT_MAX});
        to_rgb = 1'b1;
      end
      OP_VAL: begin
        cur_s  = $signed({3'b0, val_r});
        top_s  = $signed({2'b0, PCT_MAX});
        to_rgb = 1'b1;
      end
      OP_RED: begin
        cur_s = $signed({2'b0, red_r});
        top_s = $signed({2'b0, CH_MAX});
      end
      OP_GREEN: begin
        cur_s = $signed({2'b0, green_r});
        top_s = $signed({2'b0, CH_MAX});
      end
      OP_BLUE: begin
        cur_s = $signed({2'b0, blue_r});
        top_s = $signed({2'b0, CH_MAX});
      end
      default: op_ok = 1'b0;
    endcase
    if (in_new_value[9]) begin
      clv = 9'd0;
    end else if (in_new_value > top_s) begin
      clv = top_s[8:0];
    end else begin
      clv = in_new_value[8:0];
    end
  end

  // sextant, remainder, RGB extremes and hue from the last quotient
  always_comb begin
    if (hue_r >= 9'd300) begin
      sext = 3'd5;
    end else if (hue_r >= 9'd240) begin
      sext = 3'd4;
    end else if (hue_r >= 9'd180) begin
      sext = 3'd3;
    end else if (hue_r >= 9'd120) begin
      sext = 3'd2;
    end else if (hue_r >= 9'd60) begin
      sext = 3'd1;
    end else begin
      sext = 3'd0;
    end
    sext_base = 9'(sext) * 9'(SEXT_DEG);
    f_full    = hue_r - sext_base;
    f         = f_full[5:0];
    inv_sat   = PCT_MAX - {1'b0, sat_r};

    mx = (red_r > green_r) ? red_r : green_r;
    if (blue_r > mx) begin
      mx = blue_r;
    end
    mn = (red_r < green_r) ? red_r : green_r;
    if (blue_r < mn) begin
      mn = blue_r;
    end
    dd = mx - mn;

    if (red_r == mx) begin
      dif   = $signed({1'b0, green_r}) - $signed({1'b0, blue_r});
      hbase = 9'd0;
    end else if (green_r == mx) begin
      dif   = $signed({1'b0, blue_r}) - $signed({1'b0, red_r});
      hbase = HUE_GRN;
    end else begin
      dif   = $signed({1'b0, red_r}) - $signed({1'b0, green_r});
      hbase = HUE_BLU;
    end
    mag = dif[8] ? 8'(-dif) : dif[7:0];
    if (dif[8]) begin
      hs = $signed({1'b0, hbase}) - $signed({2'b0, md_q});
    end else begin
      hs = $signed({1'b0, hbase}) + $signed({2'b0, md_q});
    end
    if (hs[9]) begin
      hs = hs + $signed(FULL_DEG);
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    hue_nxt       = hue_r;
    sat_nxt       = sat_r;
    val_nxt       = val_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    sext_nxt      = sext_r;
    t_nxt         = t_r;
    lt_nxt        = lt_r;
    lz_nxt        = lz_r;
    chg_nxt       = chg_r;
    out_valid_nxt = out_valid_r & out_stall;
    o_chg_nxt     = o_chg_r;
    o_hue_nxt     = o_hue_r;
    o_sat_nxt     = o_sat_r;
    o_val_nxt     = o_val_r;
    o_red_nxt     = o_red_r;
    o_green_nxt   = o_green_r;
    o_blue_nxt    = o_blue_r;
    md_req        = '0;
    ch_wr         = 1'b0;
    ch_sel        = CH_RED;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          chg_nxt   = op_ok && (cur_s != in_new_value);
          state_nxt = S_DONE;
          if (op_ok && (cur_s != in_new_value)) begin
            state_nxt = to_rgb ? S_HSV_GO : S_RGB_GO;
            case (in_operation)
              OP_HUE:   hue_nxt   = clv;
              OP_SAT:   sat_nxt   = clv[6:0];
              OP_VAL:   val_nxt   = clv[6:0];
              OP_RED:   red_nxt   = clv[7:0];
              OP_GREEN: green_nxt = clv[7:0];
              default:  blue_nxt  = clv[7:0];
            endcase
          end
        end
      end
      S_HSV_GO: begin
        sext_nxt     = sext;
        md_req.start = 1'b1;
        md_req.a     = sext[0] ? (SEXT_DEG - {2'b0, f}) : {2'b0, f};
        md_req.b     = 8'd17;
        md_req.c     = 8'd4;
        state_nxt    = S_RF;
      end
      S_RF: begin
        if (md_done) begin
          t_nxt        = md_q;
          md_req.start = 1'b1;
          md_req.a     = inv_sat;
          md_req.b     = CH_MAX - md_q;
          md_req.c     = PCT_MAX;
          state_nxt    = S_LT;
        end
      end
      S_LT: begin
        if (md_done) begin
          lt_nxt       = md_q + t_r;
          md_req.start = 1'b1;
          md_req.a     = inv_sat;
          md_req.b     = CH_MAX;
          md_req.c     = PCT_MAX;
          state_nxt    = S_LZ;
        end
      end
      S_LZ: begin
        if (md_done) begin
          lz_nxt       = md_q;
          md_req.start = 1'b1;
          md_req.a     = {1'b0, val_r};
          md_req.b     = CH_MAX;
          md_req.c     = PCT_MAX;
          state_nxt    = S_SD;
        end
      end
      S_SD: begin
        if (md_done) begin
          ch_wr = 1'b1;
          case (sext_r) inside
            3'd1, 3'd2: ch_sel = CH_GREEN;
            3'd3, 3'd4: ch_sel = CH_BLUE;
            default:    ch_sel = CH_RED;
          endcase
          md_req.start = 1'b1;
          md_req.a     = {1'b0, val_r};
          md_req.b     = lt_r;
          md_req.c     = PCT_MAX;
          state_nxt    = S_ST;
        end
      end
      S_ST: begin
        if (md_done) begin
          ch_wr = 1'b1;
          case (sext_r) inside
            3'd1, 3'd4: ch_sel = CH_RED;
            3'd2, 3'd5: ch_sel = CH_BLUE;
            default:    ch_sel = CH_GREEN;
          endcase
          md_req.start = 1'b1;
          md_req.a     = {1'b0, val_r};
          md_req.b     = lz_r;
          md_req.c     = PCT_MAX;
          state_nxt    = S_SZ;
        end
      end
      S_SZ: begin
        if (md_done) begin
          ch_wr = 1'b1;
          case (sext_r) inside
            3'd2, 3'd3: ch_sel = CH_RED;
            3'd4, 3'd5: ch_sel = CH_GREEN;
            default:    ch_sel = CH_BLUE;
          endcase
          state_nxt = S_DONE;
        end
      end
      S_RGB_GO: begin
        md_req.start = 1'b1;
        md_req.a     = mx;
        md_req.b     = PCT_MAX;
        md_req.c     = CH_MAX;
        state_nxt    = S_RV;
      end
      S_RV: begin
        if (md_done) begin
          val_nxt = md_q[6:0];
          if (mx == 8'd0) begin
            sat_nxt   = 7'd0;
            hue_nxt   = 9'd0;
            state_nxt = S_DONE;
          end else begin
            md_req.start = 1'b1;
            md_req.a     = dd;
            md_req.b     = PCT_MAX;
            md_req.c     = mx;
            state_nxt    = S_RS;
          end
        end
      end
      S_RS: begin
        if (md_done) begin
          sat_nxt = md_q[6:0];
          if (dd == 8'd0) begin
            hue_nxt   = 9'd0;
            state_nxt = S_DONE;
          end else begin
            md_req.start = 1'b1;
            md_req.a     = SEXT_DEG;
            md_req.b     = mag;
            md_req.c     = dd;
            state_nxt    = S_RH;
          end
        end
      end
      S_RH: begin
        if (md_done) begin
          hue_nxt   = hs[8:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_chg_nxt     = chg_r;
          o_hue_nxt     = hue_r;
          o_sat_nxt     = sat_r;
          o_val_nxt     = val_r;
          o_red_nxt     = red_r;
          o_green_nxt   = green_r;
          o_blue_nxt    = blue_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (ch_wr) begin
      case (ch_sel)
        CH_GREEN: green_nxt = md_q;
        CH_BLUE:  blue_nxt  = md_q;
        default:  red_nxt   = md_q;
      endcase
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_changed   = o_chg_r;
  assign out_hue_out   = o_hue_r;
  assign out_sat_out   = o_sat_r;
  assign out_val_out   = o_val_r;
  assign out_red_out   = o_red_r;
  assign out_green_out = o_green_r;
  assign out_blue_out  = o_blue_r;

endmodule

// ----- bench/tb_colour_model_hsv_rgb_sync_unit.sv -----
// ----------------------------------------------------------------------------
// tb_colour_model_hsv_rgb_sync_unit: self-checking bench for the HSV/RGB block
// Drives component writes through the input channel and tracks the color on
// its own with truncating integer math. Every output transaction is compared
// against the oldest pending color. Both channels idle at random. The output
// side also holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_colour_model_hsv_rgb_sync_unit;
  import cmhsv_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_WRITES = 1480;
  localparam int HOLD_AT       = 600;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 250;
  localparam int MAX_SHOWN     = 40;

  typedef struct packed {
    logic       changed;
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] val;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  class colour_tracker;
    int      comp[6];
    colour_t pending[$];
    int      errors;
    int      checked;
    int      changes;
    int      hsv_writes;
    int      rgb_writes;
    int      clamped;
    int      spare_ops;

    function int top_of(logic [2:0] op);
      case (op) inside
        OP_HUE:         return HUE_MAX;
        OP_SAT, OP_VAL: return PCT_MAX;
        default:        return CH_MAX;
      endcase
    endfunction

    function int lifted(int x, int s);
      return x + (100 - s) * (255 - x) / 100;
    endfunction

    function void hsv_update();
      int h, s, v, i, f, up, dn, r, g, b;
      h = comp[OP_HUE];
      s = comp[OP_SAT];
      v = comp[OP_VAL];
      i = h / 60;
      f = h - i * 60;
      up = f * 255 / 60;
      dn = (60 - f) * 255 / 60;
      case (i)
        0:       begin r = 255; g = up;  b = 0;   end
        1:       begin r = dn;  g = 255; b = 0;   end
        2:       begin r = 0;   g = 255; b = up;  end
        3:       begin r = 0;   g = dn;  b = 255; end
        4:       begin r = up;  g = 0;   b = 255; end
        default: begin r = 255; g = 0;   b = dn;  end
      endcase
      if (i == 0 || i >= 5) begin
        g = lifted(g, s);
        b = lifted(b, s);
      end else if (i == 1 || i == 2) begin
        r = lifted(r, s);
        b = lifted(b, s);
      end else begin
        r = lifted(r, s);
        g = lifted(g, s);
      end
      comp[OP_RED]   = v * r / 100;
      comp[OP_GREEN] = v * g / 100;
      comp[OP_BLUE]  = v * b / 100;
    endfunction

    function void rgb_update();
      int r, g, b, mx, mn, d, h;
      r = comp[OP_RED];
      g = comp[OP_GREEN];
      b = comp[OP_BLUE];
      mx = (r > g) ? r : g;
      if (b > mx) mx = b;
      mn = (r < g) ? r : g;
      if (b < mn) mn = b;
      d = mx - mn;
      comp[OP_VAL] = mx * 100 / 255;
      comp[OP_SAT] = (mx != 0) ? d * 100 / mx : 0;
      h = 0;
      if (d != 0) begin
        if (r == mx) h = 60 * (g - b) / d;
        else if (g == mx) h = 120 + 60 * (b - r) / d;
        else h = 240 + 60 * (r - g) / d;
        while (h >= 360) h -= 360;
        while (h < 0) h += 360;
      end
      comp[OP_HUE] = h;
    endfunction

    function void note_write(logic [2:0] op, logic signed [9:0] raw);
      int      nv, top;
      colour_t want;
      nv = raw;
      want.changed = 1'b0;
      if (op > OP_BLUE) begin
        spare_ops++;
      end else if (comp[op] != nv) begin
        top = top_of(op);
        if (nv < 0 || nv > top) clamped++;
        comp[op] = (nv < 0) ? 0 : (nv > top) ? top : nv;
        if (op <= OP_VAL) begin
          hsv_update();
          hsv_writes++;
        end else begin
          rgb_update();
          rgb_writes++;
        end
        want.changed = 1'b1;
        changes++;
      end
      want.hue   = 9'(comp[OP_HUE]);
      want.sat   = 7'(comp[OP_SAT]);
      want.val   = 7'(comp[OP_VAL]);
      want.red   = 8'(comp[OP_RED]);
      want.green = 8'(comp[OP_GREEN]);
      want.blue  = 8'(comp[OP_BLUE]);
      pending.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_SHOWN) $display("mismatch: %s", msg);
    endtask

    task cmp(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0d expected %0d", checked, name, got, want));
    endtask

    task check_result(colour_t got);
      colour_t want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", checked));
        return;
      end
      want = pending.pop_front();
      cmp("changed", 32'(got.changed), 32'(want.changed));
      cmp("hue", 32'(got.hue), 32'(want.hue));
      cmp("sat", 32'(got.sat), 32'(want.sat));
      cmp("val", 32'(got.val), 32'(want.val));
      cmp("red", 32'(got.red), 32'(want.red));
      cmp("green", 32'(got.green), 32'(want.green));
      cmp("blue", 32'(got.blue), 32'(want.blue));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        in_operation;
  logic signed [9:0] in_new_value;
  logic              out_valid;
  logic              out_stall;
  logic              out_changed;
  logic [8:0]        out_hue_out;
  logic [6:0]        out_sat_out;
  logic [6:0]        out_val_out;
  logic [7:0]        out_red_out;
  logic [7:0]        out_green_out;
  logic [7:0]        out_blue_out;

  colour_tracker tracker;
  int            quiet_cycles = 0;
  bit            hold_req = 1'b0;

  colour_model_hsv_rgb_sync_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_new_value  (in_new_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_changed   (out_changed),
    .out_hue_out   (out_hue_out),
    .out_sat_out   (out_sat_out),
    .out_val_out   (out_val_out),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic signed [9:0] pick_value(logic [2:0] op);
    int top, r;
    top = tracker.top_of(op);
    r = $urandom_range(99);
    if (op > OP_BLUE || r < 10) return 10'($urandom);
    if (r < 20) return 10'(tracker.comp[op]);
    if (r < 30) begin
      case ($urandom_range(3))
        0:       return 10'sd0;
        1:       return 10'(top);
        2:       return 10'(top + 1);
        default: return -10'sd1;
      endcase
    end
    return 10'($urandom_range(top));
  endfunction

  task automatic send_write(logic [2:0] op, logic signed [9:0] v);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_new_value <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic idle_in(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // result check first: a result never belongs to the write taken on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        tracker.check_result({out_changed, out_hue_out, out_sat_out, out_val_out,
                              out_red_out, out_green_out, out_blue_out});
      if (in_valid && !in_stall)
        tracker.note_write(in_operation, in_new_value);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    int hold_left;
    int stall_left;
    int free_left;
    hold_left = 0;
    stall_left = 0;
    free_left = 0;
    out_stall = 1'b0;
    forever @(negedge clk) begin
      if (!rst_n) begin
        out_stall <= 1'b0;
      end else if (hold_req || hold_left > 0) begin
        if (hold_req) begin
          hold_req = 1'b0;
          hold_left = HOLD_CYCLES;
        end
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else begin
        free_left = ($urandom_range(19) == 0) ? $urandom_range(300, 100) : pick_gap();
        stall_left = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("FAIL colour_model_hsv_rgb_sync_unit");
    $finish;
  end

  initial begin
    logic [2:0]        dir_ops[$];
    int                dir_vals[$];
    logic [2:0]        op;
    int                sent;
    int                burst_left;
    int                gap;
    bit                held;
    dir_ops = '{OP_HUE, OP_SAT, OP_VAL, OP_HUE, OP_HUE, OP_HUE, OP_HUE, OP_HUE,
                OP_HUE, OP_SAT, OP_SAT, OP_SAT, OP_VAL, OP_VAL, OP_VAL, OP_RED,
                OP_GREEN, OP_BLUE, OP_RED, OP_BLUE, OP_GREEN, OP_GREEN, OP_GREEN,
                OP_RED, OP_SPARE_LO, OP_SPARE_HI};
    dir_vals = '{0, 100, 511, -512, 60, 240, 300, 359,
                 511, 0, -1, 37, 0, 100, 100, 255,
                 511, -512, 0, 255, 0, 0, 255,
                 255, 5, -1};
    tracker = new;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_HUE;
    in_new_value = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // edges, clamping, equal writes, ties, gray and the spare codes
    foreach (dir_ops[k]) begin
      idle_in(pick_gap());
      send_write(dir_ops[k], 10'(dir_vals[k]));
    end

    sent = 0;
    burst_left = 0;
    held = 1'b0;
    while (sent < RANDOM_WRITES) begin
      if (sent >= HOLD_AT && !held) begin
        hold_req = 1'b1;
        held = 1'b1;
        burst_left = 20;
      end else if (burst_left == 0 && $urandom_range(99) == 0) begin
        burst_left = $urandom_range(60, 20);
      end
      if (burst_left > 0) begin
        burst_left--;
        gap = 0;
      end else begin
        gap = pick_gap();
      end
      idle_in(gap);
      op = ($urandom_range(99) < 3) ? 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO))
                                    : 3'($urandom_range(OP_BLUE, OP_HUE));
      send_write(op, pick_value(op));
      if (op <= OP_BLUE) sent++;
    end
    in_valid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d results checked: %0d updates (%0d HSV, %0d RGB, %0d clamped)",
             tracker.checked, tracker.changes, tracker.hsv_writes, tracker.rgb_writes,
             tracker.clamped);
    $display("%0d spare-code writes, %0d mismatches", tracker.spare_ops, tracker.errors);
    if (tracker.errors == 0) begin
      $display("PASS colour_model_hsv_rgb_sync_unit");
    end else begin
      $display("FAIL colour_model_hsv_rgb_sync_unit");
    end
    $finish;
  end

endmodule
